// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// implication in the next cycle
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// ===== design/twma_pkg.sv =====
`timescale 1ns / 1ps

package twma_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int TIME_W      = 48;
  localparam int RES_W       = 36;
  localparam int ECOUNT_W    = 5;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 1'b1;

  localparam logic [TIME_W-1:0] WINDOW_LEN_RESET = 48'd1000;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_START    = 9'b000000010,
    ST_EXP_RD   = 9'b000000100,
    ST_EXP_CHK  = 9'b000001000,
    ST_APPEND   = 9'b000010000,
    ST_ROUTE    = 9'b000100000,
    ST_DIV_LOAD = 9'b001000000,
    ST_DIV_RUN  = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic in_take;
    logic exp_read;
    logic drop;
    logic append;
    logic div_start;
    logic div_step;
    logic out_load;
    logic out_from_div;
  } dp_cmd_t;

  typedef struct packed {
    logic query;
    logic count_zero;
    logic full;
    logic expired;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/twma_ctrl.sv =====
`timescale 1ns / 1ps

module twma_ctrl
  import twma_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       average_mode,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   use_div;
  logic   use_div_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      use_div <= 1'b0;
    end else begin
      state   <= state_next;
      use_div <= use_div_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    use_div_next = use_div;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_next  = ST_START;
        end
      end
      ST_START: begin
        state_next = status.query ? ST_ROUTE : ST_EXP_RD;
      end
      ST_EXP_RD: begin
        if (status.count_zero) begin
          state_next = ST_APPEND;
        end else begin
          cmd.exp_read = 1'b1;
          state_next   = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        if (status.expired) begin
          cmd.drop   = 1'b1;
          state_next = ST_EXP_RD;
        end else begin
          cmd.drop   = status.full;
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_ROUTE;
      end
      ST_ROUTE: begin
        use_div_next = average_mode && !status.count_zero;
        state_next   = (average_mode && !status.count_zero) ? ST_DIV_LOAD : ST_FINISH;
      end
      ST_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.out_from_div = use_div;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/twma_datapath.sv =====
`timescale 1ns / 1ps

module twma_datapath
  import twma_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   in_query,
  input  logic [TIME_W-1:0]      window_len,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int AW     = IDX_W + 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int EXT_W  = (SUM_W > RES_W) ? SUM_W : RES_W;
  localparam int CE_W   = (CNT_W > ECOUNT_W) ? CNT_W : ECOUNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  localparam logic signed [EXT_W-1:0] RES_MAX = EXT_W'(signed'({1'b0, {(RES_W-1){1'b1}}}));
  localparam logic signed [EXT_W-1:0] RES_MIN = EXT_W'(signed'({1'b1, {(RES_W-1){1'b0}}}));

  logic signed [SAMPLE_W-1:0] value_mem [WINDOW_DEPTH];
  logic        [TIME_W-1:0]   time_mem  [WINDOW_DEPTH];

  logic signed [SAMPLE_W-1:0] samp;
  logic        [TIME_W-1:0]   now;
  logic                       query;
  logic signed [SAMPLE_W-1:0] rd_value;
  logic        [TIME_W-1:0]   rd_time;

  logic        [IDX_W-1:0] oldest;
  logic        [CNT_W-1:0] count;
  logic signed [SUM_W-1:0] sum;

  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;
  logic              neg;

  logic [AW-1:0]           wr_sum;
  logic [IDX_W-1:0]        wr_addr;
  logic [IDX_W-1:0]        oldest_inc;
  logic [CNT_W:0]          trial;
  logic [CNT_W+1:0]        diff;
  logic signed [SUM_W-1:0] quot;
  logic signed [SUM_W-1:0] pick;
  logic signed [EXT_W-1:0] pick_ext;
  logic [RES_W-1:0]        res_sat;
  logic [CE_W-1:0]         cnt_ext;
  logic [TIME_W:0]         expire_at;

  assign wr_sum     = AW'(oldest) + AW'(count);
  assign wr_addr    = (wr_sum >= AW'(WINDOW_DEPTH)) ? IDX_W'(wr_sum - AW'(WINDOW_DEPTH))
                                                    : IDX_W'(wr_sum);
  assign oldest_inc = (oldest == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest + 1'b1;
  assign expire_at  = {1'b0, rd_time} + {1'b0, window_len};

  assign status.query      = query;
  assign status.count_zero = (count == '0);
  assign status.full       = (count == CNT_W'(WINDOW_DEPTH));
  assign status.expired    = (expire_at < {1'b0, now});
  assign status.div_last   = (dcnt == DCNT_W'(1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      samp  <= in_data[SAMPLE_W-1:0];
      now   <= in_data[SAMPLE_W +: TIME_W];
      query <= in_query;
    end
    if (cmd.exp_read) begin
      rd_value <= value_mem[oldest];
      rd_time  <= time_mem[oldest];
    end
    if (cmd.append) begin
      value_mem[wr_addr] <= samp;
      time_mem[wr_addr]  <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
      sum    <= '0;
    end else if (cmd.drop) begin
      oldest <= oldest_inc;
      count  <= count - 1'b1;
      sum    <= sum - SUM_W'(rd_value);
    end else if (cmd.append) begin
      count <= count + 1'b1;
      sum   <= sum + SUM_W'(samp);
    end
  end

  // restoring divide of the magnitude, one quotient bit per cycle
  assign trial = {rem, dvd[SUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, count};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg  <= sum[SUM_W-1];
      dvd  <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem  <= '0;
      dcnt <= DCNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - 1'b1;
      if (!diff[CNT_W+1]) begin
        rem <= diff[CNT_W-1:0];
        dvd <= {dvd[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[CNT_W-1:0];
        dvd <= {dvd[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot     = neg ? -signed'(dvd) : signed'(dvd);
  assign pick     = cmd.out_from_div ? quot : sum;
  assign pick_ext = EXT_W'(pick);
  assign res_sat  = (pick_ext > RES_MAX) ? RES_MAX[RES_W-1:0] :
                    (pick_ext < RES_MIN) ? RES_MIN[RES_W-1:0] : pick_ext[RES_W-1:0];
  assign cnt_ext  = CE_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= OUT_TDATA_W'({cnt_ext[ECOUNT_W-1:0], res_sat});
    end
  end

endmodule

// ===== design/time_window_moving_average_core.sv =====
// Time-window moving sum or average over up to WINDOW_DEPTH signed samples.
// Each input item carries a sample and its timestamp, or is a query only
// (s_tuser high). A sample first expires the oldest entries whose timestamp
// plus window_len is below the new timestamp, drops the oldest entry if the
// store is still full, then is appended. Every item returns one result item:
// the sum of the held samples, or in average mode the sum divided by the
// entry count truncated toward zero (0 when empty), with the count held.
// Items are handled one at a time. A query skips the expiry walk and the
// append; a sample walks the expiry loop, which reads and then checks the
// oldest entry, one entry at a time, until one is kept or the store is
// empty. In average mode the serial divider then produces one quotient
// bit per cycle. A finished result waits in the output register while
// the next item is taken in. Configuration writes are accepted every cycle.
`timescale 1ns / 1ps

module time_window_moving_average_core
  import twma_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample_value, sample_time
  input  logic [0:0]             s_tuser,   // query_only
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // window_result, entry_count, zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [TIME_W-1:0] window_len;
  logic              average_mode;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len   <= WINDOW_LEN_RESET;
      average_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LEN:   window_len   <= cfg_data[TIME_W-1:0];
        REG_AVERAGE_MODE: average_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  twma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .average_mode (average_mode),
    .status       (status),
    .cmd          (cmd)
  );

  twma_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_tdata),
    .in_query   (s_tuser[0]),
    .window_len (window_len),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

// ===== design/twma_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twma_checker
  import twma_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int CE_W = 9;

  logic [CE_W-1:0] ecount;

  assign ecount = CE_W'(m_tdata[RES_W +: ECOUNT_W]);

  `ASSERT_NEXT(a_one_item_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPL(a_count_bounded, clk, rst, m_tvalid, ecount <= CE_W'(WINDOW_DEPTH))
  `ASSERT_IMPL(a_empty_gives_zero, clk, rst, m_tvalid && (ecount == '0), m_tdata[RES_W-1:0] == '0)
  `ASSERT_NEXT(a_out_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind time_window_moving_average_core twma_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH)
) u_twma_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
